>>> sv/dsh_pkg.sv
// Shared constants and types for the differential steering hysteresis unit.
package dsh_pkg;

  // Field widths
  localparam int SPEED_W = 16;                 // heading length, max speed
  localparam int ANGLE_W = 15;                 // signed heading angle
  localparam int MAG_W   = 15;                 // angle magnitude (up to 16384)
  localparam int THR_W   = 14;                 // angle thresholds
  localparam int OUT_W   = SPEED_W + 2;        // signed wheel speed
  localparam int PROD_W  = SPEED_W + MAG_W;    // base * magnitude
  localparam int CNT_W   = $clog2(SPEED_W);    // divider step counter

  // Stream and configuration widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_NO_TURN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SOFT_TURN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HARD_TURN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED = 2'd3;

  // Configuration reset values
  localparam logic [THR_W-1:0]   NO_TURN_RST   = 14'd715;
  localparam logic [THR_W-1:0]   SOFT_TURN_RST = 14'd5004;
  localparam logic [THR_W-1:0]   HARD_TURN_RST = 14'd6434;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd2560;

  // Turning modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SOFT = 2'd1;
  localparam logic [1:0] MODE_HARD = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input item, update turning mode
    logic mul;        // register base * magnitude
    logic div_init;   // seed the divider from the product
    logic div_step;   // one restoring division step
    logic out_load;   // move the result into the output register
  } dsh_cmd_t;

endpackage

>>> sv/dsh_ctrl.sv
// Controller state machine: sequences capture, multiply, divide and output.
module dsh_ctrl
  import dsh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dsh_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_INIT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(SPEED_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/dsh_datapath.sv
// Datapath: config registers, turning mode, multiplier, serial divider, result register.
module dsh_datapath
  import dsh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  dsh_cmd_t                  cmd,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [ANGLE_W-1:0] heading_angle,
  input  logic [SPEED_W-1:0]        heading_length,
  output logic signed [OUT_W-1:0]   left_speed,
  output logic signed [OUT_W-1:0]   right_speed,
  output logic [1:0]                turn_mode,
  output logic                      turn_started
);

  localparam int REM_W = PROD_W - SPEED_W;

  logic [THR_W-1:0]   no_thr, soft_thr, hard_thr;
  logic [SPEED_W-1:0] spd_limit;
  logic [1:0]         mode;

  logic [MAG_W-1:0]   mag_in;
  logic [SPEED_W-1:0] base_in;
  logic [1:0]         mode_next;

  logic [MAG_W-1:0]   mag_r;
  logic [SPEED_W-1:0] base_r;
  logic               pos_r;
  logic               started_r;
  logic [PROD_W-1:0]  prod_r;
  logic [REM_W-1:0]   rem_r;
  logic [SPEED_W-1:0] quo_r;

  logic [REM_W:0]     trial;
  logic               fits;
  logic [REM_W:0]     trial_sub;

  logic [SPEED_W:0]   fast_u, slow_u;
  logic signed [OUT_W-1:0] slow_s, fast_s;
  logic               soft_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      no_thr    <= NO_TURN_RST;
      soft_thr  <= SOFT_TURN_RST;
      hard_thr  <= HARD_TURN_RST;
      spd_limit <= MAX_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NO_TURN:   no_thr    <= cfg_wdata[THR_W-1:0];
        REG_SOFT_TURN: soft_thr  <= cfg_wdata[THR_W-1:0];
        REG_HARD_TURN: hard_thr  <= cfg_wdata[THR_W-1:0];
        REG_MAX_SPEED: spd_limit <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Magnitude, clamped base speed and mode update with hysteresis
  always_comb begin
    mag_in  = heading_angle[ANGLE_W-1] ? MAG_W'(-heading_angle) : MAG_W'(heading_angle);
    base_in = (heading_length < spd_limit) ? heading_length : spd_limit;
    if (mag_in <= MAG_W'(no_thr)) begin
      mode_next = MODE_NONE;
    end else if (mag_in > MAG_W'(hard_thr)) begin
      mode_next = MODE_HARD;
    end else if (mag_in > MAG_W'(soft_thr) && mode == MODE_NONE) begin
      mode_next = MODE_SOFT;
    end else begin
      mode_next = mode;
    end
  end

  // Turning mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (cmd.load) begin
      mode <= mode_next;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r     <= mag_in;
      base_r    <= base_in;
      pos_r     <= !heading_angle[ANGLE_W-1] && (heading_angle != '0);
      started_r <= (mode_next != MODE_NONE) && (mode_next != mode);
    end
  end

  // Restoring divide step by the hard threshold
  always_comb begin
    trial     = {rem_r, quo_r[SPEED_W-1]};
    fits      = trial >= (REM_W+1)'(hard_thr);
    trial_sub = trial - (REM_W+1)'(hard_thr);
  end

  // Multiplier and divider registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(base_r) * PROD_W'(mag_r);
    end
    if (cmd.div_init) begin
      rem_r <= prod_r[PROD_W-1:SPEED_W];
      quo_r <= prod_r[SPEED_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      quo_r <= {quo_r[SPEED_W-2:0], fits};
    end
  end

  // Wheel speeds by mode (soft: fast = base + q, slow = base - ceil(base*mag/h))
  always_comb begin
    fast_u  = {1'b0, base_r} + {1'b0, quo_r};
    slow_u  = {1'b0, base_r} - {1'b0, quo_r} - {{SPEED_W{1'b0}}, (rem_r != '0)};
    soft_ok = (hard_thr != '0) && (mag_r <= MAG_W'(hard_thr));
    case (mode)
      MODE_SOFT: begin
        slow_s = soft_ok ? $signed({1'b0, slow_u}) : '0;
        fast_s = soft_ok ? $signed({1'b0, fast_u}) : '0;
      end
      MODE_HARD: begin
        slow_s = $signed(OUT_W'(0) - {2'b00, spd_limit});
        fast_s = $signed({2'b00, spd_limit});
      end
      default: begin
        slow_s = $signed({2'b00, base_r});
        fast_s = $signed({2'b00, base_r});
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_speed   <= pos_r ? slow_s : fast_s;
      right_speed  <= pos_r ? fast_s : slow_s;
      turn_mode    <= mode;
      turn_started <= started_r;
    end
  end

endmodule

>>> sv/differential_steering_hysteresis_unit.sv
// Top level: heading to wheel speeds with three-way turning mode and hysteresis.
// From input accept to result valid: multiply, divider seed, 16 divide steps,
// output load (held while the output register is busy); one item at a time,
// set by the one-bit-per-cycle divider; the next is accepted after output load.
// A result may wait in the output register while the next item is accepted.
// Reset (rst, synchronous): mode no turn, config registers to defaults, no result.
module differential_steering_hysteresis_unit
  import dsh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // tdata: [14:0] heading_angle, [30:15] heading_length, [31] unused
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // tdata: [17:0] left_speed, [35:18] right_speed, [39:36] zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,
  // tuser: [1:0] turn_mode, [2] turn_started
  output logic [OUT_USER_W-1:0]  m_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  dsh_cmd_t                cmd;
  logic signed [OUT_W-1:0] left_speed, right_speed;
  logic [1:0]              turn_mode;
  logic                    turn_started;

  dsh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  dsh_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .heading_angle  ($signed(s_tdata[ANGLE_W-1:0])),
    .heading_length (s_tdata[ANGLE_W+SPEED_W-1:ANGLE_W]),
    .left_speed     (left_speed),
    .right_speed    (right_speed),
    .turn_mode      (turn_mode),
    .turn_started   (turn_started)
  );

  // Pack result
  assign m_tdata = {{(OUT_DATA_W - 2*OUT_W){1'b0}}, right_speed, left_speed};
  assign m_tuser = {turn_started, turn_mode};

endmodule
